[rtl/rfsd_pkg.sv]
// ----------------------------------------------------------------------------
// rfsd_pkg
// Shared types, constants and arithmetic helpers for the RGB565
// error-diffusion dither block.
// ----------------------------------------------------------------------------
package rfsd_pkg;

    // Field and register widths
    localparam int PIX_W    = 16;
    localparam int WIDTH_W  = 9;
    localparam int HEIGHT_W = 16;
    localparam int ERR_W    = 12;
    localparam int LUMA_W   = 8;
    localparam int SUM_W    = 18;
    localparam int ARITH_W  = 18;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Defaults
    localparam int DEF_LINE_DEPTH = 384;
    localparam int RESET_WIDTH    = 384;
    localparam int RESET_HEIGHT   = 1;

    // Queue sizes
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 2;

    // Channel widening: x8 = (x * scale + bias) >> 6
    localparam int RB_SCALE = 527;
    localparam int RB_BIAS  = 23;
    localparam int G_SCALE  = 259;
    localparam int G_BIAS   = 33;
    localparam int EXP_SHIFT = 6;

    // Luminance weights over 1000
    localparam int WEIGHT_R = 299;
    localparam int WEIGHT_G = 587;
    localparam int WEIGHT_B = 114;

    // Divide by 1000 as multiply by ceil(2^28 / 1000), exact for sums below 493447
    localparam int RECIP       = 268436;
    localparam int RECIP_SHIFT = 28;
    localparam int PROD_W      = SUM_W + 19;

    localparam int THRESHOLD   = 127;
    localparam int WHITE_LEVEL = 255;

    // Register map, indexed by paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [WIDTH_W-1:0] col;
        logic               first_row;
        logic               last_col;
        logic               last_row;
    } t_tag;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        t_tag              tag;
    } t_item;

    typedef struct packed {
        logic dot_black;
        logic end_of_row;
        logic end_of_image;
    } t_result;

    typedef enum logic [1:0] {
        S_FETCH,
        S_EXEC,
        S_TAIL
    } t_back_state;

    // Signed divide by 16, truncating toward zero
    function automatic logic signed [ARITH_W-1:0] div16(input logic signed [ARITH_W-1:0] v);
        logic signed [ARITH_W-1:0] biased;
        biased = v + (v[ARITH_W-1] ? ARITH_W'(15) : ARITH_W'(0));
        return biased >>> 4;
    endfunction

    // Saturate to the 12-bit stored error range
    function automatic logic signed [ERR_W-1:0] sat12(input logic signed [ARITH_W-1:0] v);
        logic signed [ERR_W-1:0] res;
        if (v > ARITH_W'(2047)) begin
            res = 12'sd2047;
        end else if (v < -ARITH_W'(2048)) begin
            res = -12'sd2048;
        end else begin
            res = v[ERR_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/rfsd_ram.sv]
// ----------------------------------------------------------------------------
// rfsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rfsd_queue.sv]
// ----------------------------------------------------------------------------
// rfsd_queue
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
module rfsd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/rfsd_front.sv]
// ----------------------------------------------------------------------------
// rfsd_front
// Accepts pixels, tracks raster position, tags edges and computes luminance
// in a three-stage pipeline that feeds the work queue.
// ----------------------------------------------------------------------------
module rfsd_front import rfsd_pkg::*; #(
    parameter int LINE_DEPTH = DEF_LINE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_push,
    output logic               o_full,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic [Q_CNT_W-1:0] i_q_count,
    output logic               o_item_valid,
    output t_item              o_item
);

    localparam int UW = Q_CNT_W + 2;

    logic [WIDTH_W-1:0]  r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic                r_v1, r_v2, r_v3;
    logic [LUMA_W-1:0]   r_r8, r_g8, r_b8;
    logic [SUM_W-1:0]    r_sum;
    logic [LUMA_W-1:0]   r_luma;
    t_tag                r_tag1, r_tag2, r_tag3;

    logic [WIDTH_W-1:0]  w_nz, w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [UW-1:0]       used;
    logic                accept;
    logic                last_col, last_row;
    t_tag                tag;
    logic [13:0]         r_wide, g_wide, b_wide;
    logic [SUM_W-1:0]    sum;
    logic [PROD_W-1:0]   prod;

    // Effective geometry: zero means one, width clamps to the line store
    assign w_nz  = (i_cfg.width == '0) ? WIDTH_W'(1) : i_cfg.width;
    assign w_eff = (32'(w_nz) > LINE_DEPTH) ? WIDTH_W'(LINE_DEPTH) : w_nz;
    assign h_eff = (i_cfg.height == '0) ? HEIGHT_W'(1) : i_cfg.height;

    // Credit: queue entries plus words still in the pipeline
    assign used   = UW'(i_q_count) + UW'(r_v1) + UW'(r_v2) + UW'(r_v3);
    assign o_full = (used >= UW'(QUEUE_DEPTH));
    assign accept = i_push && !o_full;

    assign last_col = ({1'b0, r_col} + 10'd1) >= {1'b0, w_eff};
    assign last_row = ({1'b0, r_row} + 17'd1) >= {1'b0, h_eff};

    always_comb begin
        tag.col       = r_col;
        tag.first_row = (r_row == '0);
        tag.last_col  = last_col;
        tag.last_row  = last_row;
    end

    assign r_wide = 14'(i_pixel[15:11]) * 14'(RB_SCALE) + 14'(RB_BIAS);
    assign g_wide = 14'(i_pixel[10:5]) * 14'(G_SCALE) + 14'(G_BIAS);
    assign b_wide = 14'(i_pixel[4:0]) * 14'(RB_SCALE) + 14'(RB_BIAS);

    assign sum = SUM_W'(r_r8) * SUM_W'(WEIGHT_R)
               + SUM_W'(r_g8) * SUM_W'(WEIGHT_G)
               + SUM_W'(r_b8) * SUM_W'(WEIGHT_B);

    assign prod = PROD_W'(r_sum) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + HEIGHT_W'(1);
                end else begin
                    r_col <= r_col + WIDTH_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r8   <= LUMA_W'(r_wide >> EXP_SHIFT);
        r_g8   <= LUMA_W'(g_wide >> EXP_SHIFT);
        r_b8   <= LUMA_W'(b_wide >> EXP_SHIFT);
        r_tag1 <= tag;
        r_sum  <= sum;
        r_tag2 <= r_tag1;
        r_luma <= prod[RECIP_SHIFT +: LUMA_W];
        r_tag3 <= r_tag2;
    end

    assign o_item_valid = r_v3;
    always_comb begin
        o_item.luma = r_luma;
        o_item.tag  = r_tag3;
    end

endmodule

[rtl/rfsd_back.sv]
// ----------------------------------------------------------------------------
// rfsd_back
// Error-diffusion engine: reads the stored error for the column, thresholds,
// spreads the error and writes the next-row line store.
// ----------------------------------------------------------------------------
module rfsd_back import rfsd_pkg::*; #(
    parameter int LINE_DEPTH = DEF_LINE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_q_empty,
    output logic    o_q_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    t_back_state             r_state, n_state;
    t_item                   r_item, n_item;
    logic signed [ERR_W-1:0] r_carry, n_carry;
    logic signed [ERR_W-1:0] r_psl, n_psl;
    logic signed [ERR_W-1:0] r_psm, n_psm;
    logic signed [ERR_W-1:0] r_tail, n_tail;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [ERR_W-1:0]          ram_wdata, ram_rdata;

    logic signed [ERR_W-1:0]   above_err;
    logic signed [ARITH_W-1:0] above, luma, left_in, val, err;
    logic signed [ARITH_W-1:0] left, mid;
    logic signed [ERR_W-1:0]   psl_new;
    logic                      first_col, white, has_right, has_below;

    rfsd_ram #(
        .WIDTH (ERR_W),
        .DEPTH (LINE_DEPTH)
    ) u_err_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Read for the word at the queue head; data is ready in S_EXEC
    assign ram_raddr = AW'(i_item.tag.col);

    assign first_col = (r_item.tag.col == '0);
    assign has_right = !r_item.tag.last_col;
    assign has_below = !r_item.tag.last_row;

    always_comb begin
        above_err = ram_rdata;
        above     = r_item.tag.first_row ? '0 : ARITH_W'(above_err);
        luma      = signed'(ARITH_W'(r_item.luma));
        left_in   = first_col ? '0 : ARITH_W'(r_carry);
        val       = luma + above + left_in;
        white     = val > ARITH_W'(THRESHOLD);
        err       = white ? val - ARITH_W'(WHITE_LEVEL) : val;
        left      = first_col ? '0 : ARITH_W'(r_psl);
        mid       = first_col ? '0 : ARITH_W'(r_psm);
        psl_new   = sat12(mid + div16(err * ARITH_W'(5)));
    end

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_carry    = r_carry;
        n_psl      = r_psl;
        n_psm      = r_psm;
        n_tail     = r_tail;
        o_q_pop    = 1'b0;
        o_res_push = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = AW'(r_item.tag.col);
        ram_wdata  = r_tail;
        case (r_state)
            S_FETCH: begin
                if (!i_q_empty && !i_res_full) begin
                    o_q_pop = 1'b1;
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_res_push = 1'b1;
                n_carry    = has_right ? sat12(div16(err * ARITH_W'(7))) : '0;
                n_tail     = psl_new;
                if (has_below) begin
                    if (!first_col) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(r_item.tag.col - WIDTH_W'(1));
                        ram_wdata = sat12(left + div16(err * ARITH_W'(3)));
                    end
                    n_psl = psl_new;
                    n_psm = has_right ? sat12(div16(err)) : '0;
                end else begin
                    n_psl = '0;
                    n_psm = '0;
                end
                if (r_item.tag.last_col) begin
                    n_carry = '0;
                    n_psl   = '0;
                    n_psm   = '0;
                end
                n_state = (r_item.tag.last_col && has_below) ? S_TAIL : S_FETCH;
            end
            S_TAIL: begin
                // Last column's pending sum goes straight to its own entry
                ram_we    = 1'b1;
                ram_waddr = AW'(r_item.tag.col);
                ram_wdata = r_tail;
                n_state   = S_FETCH;
            end
            default: begin
                n_state = S_FETCH;
            end
        endcase
    end

    always_comb begin
        o_res.dot_black    = !white;
        o_res.end_of_row   = r_item.tag.last_col;
        o_res.end_of_image = r_item.tag.last_col && r_item.tag.last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FETCH;
            r_carry <= '0;
            r_psl   <= '0;
            r_psm   <= '0;
        end else begin
            r_state <= n_state;
            r_carry <= n_carry;
            r_psl   <= n_psl;
            r_psm   <= n_psm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_tail <= n_tail;
    end

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full output queue");

    a_no_last_row_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_item.tag.last_row)
        else $error("line store written on the last row");

    a_tail_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL) |-> ($past(r_state) == S_EXEC && r_item.tag.last_col))
        else $error("tail write not after a row-ending word");

    a_pop_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_EXEC))
        else $error("popped word not processed next cycle");

endmodule

[rtl/rgb565_floyd_steinberg_dither.sv]
// ----------------------------------------------------------------------------
// rgb565_floyd_steinberg_dither
// The back end takes one word at a time: fetch (the registered read of the
// next-row error store), execute and, for the last pixel of a row that has
// a row below, a tail write; it fetches only while the result queue has room.
// The front end takes one word per cycle until the work queue credit runs
// out. Reset (synchronous, active low) clears counters, queues, carries and
// the config to width 384, height 1.
// ----------------------------------------------------------------------------
// Top level: APB config registers, the front end (position tracking and
// luminance), the work queue, the diffusion back end and the result queue.
// ----------------------------------------------------------------------------
module rgb565_floyd_steinberg_dither import rfsd_pkg::*; #(
    parameter int LINE_DEPTH = DEF_LINE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel input queue side
    input  logic              push,
    output logic              full,
    input  logic [PIX_W-1:0]  i_pixel_rgb565,
    // dot output queue side
    output logic              empty,
    input  logic              pop,
    output logic              o_dot_black,
    output logic              o_end_of_row,
    output logic              o_end_of_image,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg               r_cfg;
    logic               cfg_wr;

    logic               item_valid;
    t_item              item_in, item_head;
    logic               q_empty, q_pop;
    logic [Q_CNT_W-1:0] q_count;

    logic               res_push, res_full;
    t_result            res_in, res_head;

    // ---------------- configuration port ----------------
    // Zero wait states; paddr[2] picks the register, words are 4 bytes apart.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_W'(RESET_WIDTH);
            r_cfg.height <= HEIGHT_W'(RESET_HEIGHT);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WIDTH:  r_cfg.width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: r_cfg.height <= pwdata[HEIGHT_W-1:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = DATA_W'(r_cfg.width);
            REG_HEIGHT: prdata = DATA_W'(r_cfg.height);
            default:    prdata = '0;
        endcase
    end

    // ---------------- front end ----------------
    // Tag row/column edges at accept time and compute luminance; full is a
    // credit check so the pipeline never has to stall.
    rfsd_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .o_full       (full),
        .i_pixel      (i_pixel_rgb565),
        .i_q_count    (q_count),
        .o_item_valid (item_valid),
        .o_item       (item_in)
    );

    // ---------------- work queue ----------------
    // Decouple the front pipeline from the back end, which takes one word at a time.
    rfsd_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_valid),
        .i_data  (item_in),
        .i_pop   (q_pop),
        .o_data  (item_head),
        .o_empty (q_empty),
        .o_full  (),
        .o_count (q_count)
    );

    // ---------------- back end ----------------
    // Threshold, spread the error and maintain the next-row line store.
    rfsd_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_head),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    // ---------------- result queue ----------------
    // Hold finished words so the back end keeps going while the sink stalls, until the queue is full.
    rfsd_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty),
        .o_full  (res_full),
        .o_count ()
    );

    assign o_dot_black    = res_head.dot_black;
    assign o_end_of_row   = res_head.end_of_row;
    assign o_end_of_image = res_head.end_of_image;

endmodule

[bench/rgb565_floyd_steinberg_dither_tb.sv]
// ----------------------------------------------------------------------------
// rgb565_floyd_steinberg_dither_tb
// Self-checking bench for the RGB565 error-diffusion dither block. A short
// scripted run walks reset values, channel extremes, zero and oversize
// register values and register changes in the middle of an image. Random
// images with random content follow. A shadow copy of the diffusion state
// predicts the dots the script does not give by hand, and each word popped
// from the block is checked field by field against the oldest dot owed.
// ----------------------------------------------------------------------------
module rgb565_floyd_steinberg_dither_tb;
    import rfsd_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_GAP   = 8;        // latency of the block plus margin
    localparam int LIMIT_CYCLES = 400_000;
    localparam int N_ITEMS      = 700;

    typedef enum logic {
        ROW_PIX,
        ROW_CFG
    } t_row_kind;

    // One step of the scripted run: a pixel word or a register write.
    // For pixels, typed selects the hand-written dot over the predicted one.
    typedef struct packed {
        t_row_kind    kind;
        logic         sel;
        logic [15:0]  data;
        logic         typed;
        t_result      want;
    } t_script_row;

    localparam int N_SCRIPT = 32;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                push           = 1'b0;
    logic                pop            = 1'b0;
    logic [PIX_W-1:0]    i_pixel_rgb565 = '0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic                full;
    logic                empty;
    logic                o_dot_black;
    logic                o_end_of_row;
    logic                o_end_of_image;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    rgb565_floyd_steinberg_dither uut (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_pixel_rgb565,
        .empty,
        .pop,
        .o_dot_black,
        .o_end_of_row,
        .o_end_of_image,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    // ------------------------------------------------------------------
    // Shadow of the block: configuration, error store, carries, position
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0]      cfg_width;
    logic [HEIGHT_W-1:0]     cfg_height;
    logic signed [ERR_W-1:0] below_err [DEF_LINE_DEPTH];
    logic signed [ERR_W-1:0] carry_right;
    logic signed [ERR_W-1:0] sum_left;
    logic signed [ERR_W-1:0] sum_mid;
    logic [WIDTH_W-1:0]      col_cnt;
    logic [HEIGHT_W-1:0]     row_cnt;

    // Dots still owed by the block, oldest first
    t_result dots_due [$];

    int send_idle_pct = 33;
    int recv_idle_pct = 78;
    int mismatches    = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int images_done   = 0;
    int cfg_writes    = 0;
    int cycles        = 0;

    t_script_row script [N_SCRIPT];

    function automatic logic signed [ERR_W-1:0] clamp_err(input int v);
        if (v > 2047) begin
            return 12'sd2047;
        end
        if (v < -2048) begin
            return -12'sd2048;
        end
        return v[ERR_W-1:0];
    endfunction

    // Widen each channel to 8 bits, then weight 299/587/114 over 1000
    function automatic int pixel_luma(input logic [PIX_W-1:0] p);
        int r8, g8, b8;
        r8 = (int'(p[15:11]) * RB_SCALE + RB_BIAS) >> EXP_SHIFT;
        g8 = (int'(p[10:5]) * G_SCALE + G_BIAS) >> EXP_SHIFT;
        b8 = (int'(p[4:0]) * RB_SCALE + RB_BIAS) >> EXP_SHIFT;
        return (r8 * WEIGHT_R + g8 * WEIGHT_G + b8 * WEIGHT_B) / 1000;
    endfunction

    // Width zero acts as one; anything past the head width clips to it
    function int eff_width();
        if (cfg_width == 0) begin
            return 1;
        end
        return (cfg_width > DEF_LINE_DEPTH) ? DEF_LINE_DEPTH : int'(cfg_width);
    endfunction

    function int eff_height();
        return (cfg_height == 0) ? 1 : int'(cfg_height);
    endfunction

    function void reset_shadow();
        cfg_width   = RESET_WIDTH;
        cfg_height  = RESET_HEIGHT;
        carry_right = '0;
        sum_left    = '0;
        sum_mid     = '0;
        col_cnt     = '0;
        row_cnt     = '0;
        foreach (below_err[i]) begin
            below_err[i] = '0;
        end
    endfunction

    // Dither one pixel against the shadow state and advance it
    task dither_pixel(input logic [PIX_W-1:0] p, output t_result res);
        int  w, h, x, y, above, val, err, left, mid;
        bit  last_col, last_row, white;
        w        = eff_width();
        h        = eff_height();
        x        = col_cnt;
        y        = row_cnt;
        last_col = (x + 1 >= w);
        last_row = (y + 1 >= h);

        // the first row ignores whatever sits in the store
        above = (y > 0) ? int'(below_err[x]) : 0;
        val   = pixel_luma(p) + above + ((x > 0) ? int'(carry_right) : 0);
        white = (val > THRESHOLD);
        err   = white ? val - WHITE_LEVEL : val;

        carry_right = last_col ? '0 : clamp_err((err * 7) / 16);

        if (!last_row) begin
            left = (x > 0) ? int'(sum_left) : 0;
            mid  = (x > 0) ? int'(sum_mid) : 0;
            // close out the column to the lower left, shift the partial sums
            if (x > 0) begin
                below_err[x-1] = clamp_err(left + (err * 3) / 16);
            end
            sum_left = clamp_err(mid + (err * 5) / 16);
            sum_mid  = last_col ? '0 : clamp_err(err / 16);
            if (last_col) begin
                below_err[x] = sum_left;
            end
        end else begin
            // last row: nothing goes below, drop the partial sums
            sum_left = '0;
            sum_mid  = '0;
        end

        res.dot_black    = !white;
        res.end_of_row   = last_col;
        res.end_of_image = last_col && last_row;

        if (last_col) begin
            col_cnt     = '0;
            carry_right = '0;
            sum_left    = '0;
            sum_mid     = '0;
            row_cnt     = last_row ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d dots still owed", cycles,
                     dots_due.size());
            $display("rgb565_floyd_steinberg_dither_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Pixel side: hold push high across back-to-back words, drop it only
    // for an idle gap or before the bench goes quiet
    // ------------------------------------------------------------------
    task send_word(input logic [PIX_W-1:0] p, input logic typed, input t_result want);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_pixel_rgb565 <= p;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        // the block took the word at this edge
        dither_pixel(p, res);
        dots_due.push_back(typed ? want : res);
        words_sent++;
    endtask

    // Stop pushing and wait for every owed dot, then let the pipe go quiet
    task settle();
        push <= 1'b0;
        while (dots_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    // Write a register with junk above its width, then read it back
    task write_reg(input logic sel, input logic [15:0] value);
        logic [DATA_W-1:0] mask, junk, seen;
        mask = (sel == REG_WIDTH) ? 32'h0000_01FF : 32'h0000_FFFF;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= (junk & ~mask) | (DATA_W'(value) & mask);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        // register updated at this edge
        if (sel == REG_WIDTH) begin
            cfg_width = value[WIDTH_W-1:0];
        end else begin
            cfg_height = value;
        end
        cfg_writes++;
        // keep psel high and go straight into the read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        seen = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((seen & mask) !== (DATA_W'(value) & mask)) begin
            $display("%0t: readback of register at 0x%0h: expected 0x%0h, got 0x%0h",
                     $time, {sel, 2'b00}, DATA_W'(value) & mask, seen & mask);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Dot side: pop at random, check each word against the oldest dot owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : dot_monitor
        t_result got, want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got = {o_dot_black, o_end_of_row, o_end_of_image};
                if (dots_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %b", $time, got);
                    mismatches++;
                end else begin
                    want = dots_due.pop_front();
                    words_checked++;
                    if (got.dot_black !== want.dot_black) begin
                        $display("%0t: dot_black: expected %0b, got %0b",
                                 $time, want.dot_black, got.dot_black);
                        mismatches++;
                    end
                    if (got.end_of_row !== want.end_of_row) begin
                        $display("%0t: end_of_row: expected %0b, got %0b",
                                 $time, want.end_of_row, got.end_of_row);
                        mismatches++;
                    end
                    if (got.end_of_image !== want.end_of_image) begin
                        $display("%0t: end_of_image: expected %0b, got %0b",
                                 $time, want.end_of_image, got.end_of_image);
                        mismatches++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // One random image: pick a size, stream pixels until the image ends,
    // and sometimes shrink the size part way through
    // ------------------------------------------------------------------
    task run_image();
        logic [15:0]     wreg, hreg, base, p;
        int              cm, n, break_at;
        bit              forced;
        case ($urandom_range(0, 19))
            0:       wreg = 16'd0;
            1:       wreg = 16'd1;
            2:       wreg = 16'($urandom_range(DEF_LINE_DEPTH, 511));
            3:       wreg = 16'($urandom_range(41, DEF_LINE_DEPTH - 1));
            default: wreg = 16'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 15))
            0:       hreg = 16'd0;
            1:       hreg = 16'hFFFF;
            2:       hreg = 16'($urandom_range(21, 65535));
            default: hreg = 16'($urandom_range(1, 6));
        endcase
        settle();
        write_reg(REG_WIDTH, wreg);
        write_reg(REG_HEIGHT, hreg);

        // big images always get cut short; small ones now and then
        forced   = (eff_width() > 40) || (eff_height() > 20);
        break_at = forced ? $urandom_range(1, 8)
                          : (($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0);
        cm   = $urandom_range(0, 3);
        base = 16'($urandom);
        n    = 0;
        do begin
            case (cm)
                1: p = base ^ 16'($urandom & 32'h0000_0841);   // flat tone with noise
                2: case ($urandom_range(0, 4))
                       0: p = 16'h0000;
                       1: p = 16'hFFFF;
                       2: p = 16'hF800;
                       3: p = 16'h07E0;
                       default: p = 16'h001F;
                   endcase
                default: p = 16'($urandom);
            endcase
            send_word(p, 1'b0, '0);
            n++;
            if (n == break_at && (col_cnt != 0 || row_cnt != 0)) begin
                // only shrink mid-image, so no row reads a store entry never written
                settle();
                if (forced) begin
                    if (eff_width() > 40) begin
                        write_reg(REG_WIDTH, 16'($urandom_range(0, 8)));
                    end
                    if (eff_height() > 20) begin
                        write_reg(REG_HEIGHT, 16'($urandom_range(0, 3)));
                    end
                end else if ($urandom_range(0, 1)) begin
                    write_reg(REG_WIDTH, 16'($urandom_range(0, eff_width())));
                end else begin
                    write_reg(REG_HEIGHT, 16'($urandom_range(0, eff_height())));
                end
            end
        end while (col_cnt != 0 || row_cnt != 0);
        images_done++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int send_pct [3];
        int recv_pct [3];
        int goal;
        send_pct = '{33, 78, 0};
        recv_pct = '{78, 33, 0};

        // Scripted run. The first rows use the reset size (384 by 1); the
        // width then drops under the column count so the next pixel closes
        // the row and the image. Zero sizes act as one. A column image and
        // a 3x2 image carry errors down and right. Last, an oversize width
        // and full height are cut back mid-row and mid-image.
        script = '{
            '{ROW_PIX, REG_WIDTH,  16'h0000, 1'b1, 3'b100},
            '{ROW_PIX, REG_WIDTH,  16'hFFFF, 1'b1, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h0000, 1'b1, 3'b100},
            '{ROW_CFG, REG_WIDTH,  16'd2,    1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'hFFFF, 1'b1, 3'b011},
            '{ROW_CFG, REG_WIDTH,  16'd0,    1'b0, 3'b000},
            '{ROW_CFG, REG_HEIGHT, 16'd0,    1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h0000, 1'b1, 3'b111},
            '{ROW_PIX, REG_WIDTH,  16'hFFFF, 1'b1, 3'b011},
            '{ROW_CFG, REG_WIDTH,  16'd1,    1'b0, 3'b000},
            '{ROW_CFG, REG_HEIGHT, 16'd3,    1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h8410, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h7BEF, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h0841, 1'b0, 3'b000},
            '{ROW_CFG, REG_WIDTH,  16'd3,    1'b0, 3'b000},
            '{ROW_CFG, REG_HEIGHT, 16'd2,    1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'hF800, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h07E0, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h001F, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h7BEF, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'hFFDF, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h8410, 1'b0, 3'b000},
            '{ROW_CFG, REG_WIDTH,  16'd511,  1'b0, 3'b000},
            '{ROW_CFG, REG_HEIGHT, 16'hFFFF, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h4208, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'hC618, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h39E7, 1'b0, 3'b000},
            '{ROW_CFG, REG_WIDTH,  16'd2,    1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h0020, 1'b0, 3'b000},
            '{ROW_CFG, REG_HEIGHT, 16'd1,    1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'hFFE0, 1'b0, 3'b000},
            '{ROW_PIX, REG_WIDTH,  16'h001F, 1'b0, 3'b000}
        };

        reset_shadow();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = send_pct[0];
        recv_idle_pct = recv_pct[0];
        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                settle();
                write_reg(script[i].sel, script[i].data);
            end else begin
                send_word(script[i].data, script[i].typed, script[i].want);
            end
        end

        // Random images, one idle pattern per phase; the last phase also
        // runs one full head-width row
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            goal = (ph + 1) * (N_ITEMS - DEF_LINE_DEPTH) / 3;
            if (ph == 2) begin
                goal = N_ITEMS;
                // one row at full head width to touch the last column, then
                // a short second row that reads back what the first stored
                settle();
                write_reg(REG_WIDTH, $urandom_range(0, 1) ? 16'd384 : 16'd511);
                write_reg(REG_HEIGHT, 16'd2);
                do begin
                    send_word(16'($urandom), 1'b0, '0);
                end while (col_cnt != 0);
                settle();
                write_reg(REG_WIDTH, 16'($urandom_range(1, 8)));
                do begin
                    send_word(16'($urandom), 1'b0, '0);
                end while (col_cnt != 0 || row_cnt != 0);
                images_done++;
            end
            while (words_sent < goal) begin
                run_image();
            end
        end

        // drain, then watch a while longer for stray words
        settle();
        $display("dithered %0d pixels in %0d random images plus a scripted run;",
                 words_sent, images_done);
        $display("%0d dots checked, %0d register writes read back",
                 words_checked, cfg_writes);
        if (mismatches == 0) begin
            $display("rgb565_floyd_steinberg_dither_tb: PASS");
        end else begin
            $display("rgb565_floyd_steinberg_dither_tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/rfsd_pkg.sv
rtl/rfsd_ram.sv
rtl/rfsd_queue.sv
rtl/rfsd_front.sv
rtl/rfsd_back.sv
rtl/rgb565_floyd_steinberg_dither.sv
bench/rgb565_floyd_steinberg_dither_tb.sv
